@@ rtl/mct_pkg.sv @@
// Shared types and constants of the match and capture timer.
`default_nettype none

package mct_pkg;

	localparam int NUM_MATCH   = 4;
	localparam int NUM_CAPTURE = 2;
	localparam int NUM_FLAGS   = NUM_MATCH + NUM_CAPTURE;
	localparam int ADDR_W      = 5;
	localparam int DATA_W      = 32;

	typedef enum logic [2:0] {
		OP_TICK    = 3'd0,
		OP_CONTROL = 3'd1,
		OP_COUNTER = 3'd2,
		OP_CLEAR   = 3'd3,
		OP_READ    = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		REG_PRESCALE_LIMIT  = 3'd0,
		REG_MATCH_CONTROL   = 3'd1,
		REG_MATCH_VALUE_0   = 3'd2,
		REG_MATCH_VALUE_1   = 3'd3,
		REG_MATCH_VALUE_2   = 3'd4,
		REG_MATCH_VALUE_3   = 3'd5,
		REG_CAPTURE_CONTROL = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] write_data;
		logic [1:0]  capture_pins;
	} in_word_t;

	typedef struct packed {
		logic [31:0] timer_count;
		logic [5:0]  flag_bits;
		logic        interrupt_request;
		logic [31:0] captured_value_0;
		logic [31:0] captured_value_1;
	} out_word_t;

	typedef struct packed {
		logic [31:0]                prescale_limit;
		logic [7:0]                 match_control;
		logic [NUM_MATCH-1:0][31:0] match_value;
		logic [5:0]                 capture_control;
	} cfg_t;

endpackage

`default_nettype wire

@@ rtl/mct_regs.sv @@
// Configuration register file of the match and capture timer with its APB access.
`default_nettype none

module mct_regs (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [mct_pkg::ADDR_W-1:0] paddr,
	input  wire logic [mct_pkg::DATA_W-1:0] pwdata,
	output logic      [mct_pkg::DATA_W-1:0] prdata,
	output mct_pkg::cfg_t                   cfg
);
	import mct_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign wr_en = psel && penable && pwrite;
	assign idx   = paddr[ADDR_W-1:2];
	assign cfg   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_PRESCALE_LIMIT:  cfg_q.prescale_limit  <= pwdata;
				REG_MATCH_CONTROL:   cfg_q.match_control   <= pwdata[7:0];
				REG_MATCH_VALUE_0:   cfg_q.match_value[0]  <= pwdata;
				REG_MATCH_VALUE_1:   cfg_q.match_value[1]  <= pwdata;
				REG_MATCH_VALUE_2:   cfg_q.match_value[2]  <= pwdata;
				REG_MATCH_VALUE_3:   cfg_q.match_value[3]  <= pwdata;
				REG_CAPTURE_CONTROL: cfg_q.capture_control <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_PRESCALE_LIMIT:  prdata = cfg_q.prescale_limit;
			REG_MATCH_CONTROL:   prdata = {24'd0, cfg_q.match_control};
			REG_MATCH_VALUE_0:   prdata = cfg_q.match_value[0];
			REG_MATCH_VALUE_1:   prdata = cfg_q.match_value[1];
			REG_MATCH_VALUE_2:   prdata = cfg_q.match_value[2];
			REG_MATCH_VALUE_3:   prdata = cfg_q.match_value[3];
			REG_CAPTURE_CONTROL: prdata = {26'd0, cfg_q.capture_control};
			default:             prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/match_capture_timer_core.sv @@
// Top level of the prescaled 32-bit timer with four match and two capture channels.
//
// The timer takes one word per clock cycle while in_stall is low, whether a tick, a control,
// counter or flag-clear write, or a read, and returns exactly one result word for each; a word
// passes through the input register and then the result register. Counter, prescaler, flag and
// capture state is updated as a word moves on into the result register, so back-to-back ticks
// see each other's effects with no extra delay.
`default_nettype none

module match_capture_timer_core (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire mct_pkg::in_word_t          in_word,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output mct_pkg::out_word_t              out_word,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [mct_pkg::ADDR_W-1:0] paddr,
	input  wire logic [mct_pkg::DATA_W-1:0] pwdata,
	output logic      [mct_pkg::DATA_W-1:0] prdata,
	output logic                            pready
);
	import mct_pkg::*;

	cfg_t      cfg;
	in_word_t  in_word_s1;
	logic      valid_s1;
	out_word_t out_word_q;
	logic      out_valid_q;
	logic      adv;

	logic [31:0]                  count_q, count_d;
	logic [31:0]                  presc_q, presc_d;
	logic                         run_q, run_d;
	logic                         hold_q, hold_d;
	logic [NUM_FLAGS-1:0]         flags_q, flags_d;
	logic [NUM_CAPTURE-1:0][31:0] cap_q, cap_d;
	logic [NUM_CAPTURE-1:0]       pins_q, pins_d;
	logic                         clr;

	mct_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.cfg    (cfg)
	);

	assign pready    = 1'b1;
	assign adv       = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !adv;
	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	always_comb begin
		logic       now_b;
		logic       was_b;
		logic [2:0] sel;
		now_b   = 1'b0;
		was_b   = 1'b0;
		sel     = '0;
		count_d = count_q;
		presc_d = presc_q;
		run_d   = run_q;
		hold_d  = hold_q;
		flags_d = flags_q;
		cap_d   = cap_q;
		pins_d  = pins_q;
		clr     = 1'b0;
		unique case (in_word_s1.op)
			OP_TICK: begin
				if (run_q && !hold_q) begin
					if (presc_q == cfg.prescale_limit) begin
						presc_d = '0;
						for (int m = 0; m < NUM_MATCH; m++) begin
							if (cfg.match_value[m] == count_q) begin
								if (cfg.match_control[2*m]) begin
									flags_d[m] = 1'b1;
								end
								if (cfg.match_control[2*m+1]) begin
									clr = 1'b1;
								end
							end
						end
						count_d = clr ? '0 : count_q + 32'd1;
					end else begin
						presc_d = presc_q + 32'd1;
					end
				end
				for (int c = 0; c < NUM_CAPTURE; c++) begin
					now_b = in_word_s1.capture_pins[c];
					was_b = pins_q[c];
					sel   = cfg.capture_control[3*c +: 3];
					if ((sel[0] && !was_b && now_b) || (sel[1] && was_b && !now_b)) begin
						cap_d[c] = count_q;
						if (sel[2]) begin
							flags_d[NUM_MATCH + c] = 1'b1;
						end
					end
				end
				pins_d = in_word_s1.capture_pins;
			end
			OP_CONTROL: begin
				run_d  = in_word_s1.write_data[0];
				hold_d = in_word_s1.write_data[1];
				if (in_word_s1.write_data[1]) begin
					count_d = '0;
					presc_d = '0;
				end
			end
			OP_COUNTER: begin
				count_d = in_word_s1.write_data;
			end
			OP_CLEAR: begin
				flags_d = flags_q & ~in_word_s1.write_data[NUM_FLAGS-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			in_word_s1 <= in_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			presc_q <= '0;
			run_q   <= 1'b0;
			hold_q  <= 1'b0;
			flags_q <= '0;
			cap_q   <= '0;
			pins_q  <= '0;
		end else if (adv) begin
			count_q <= count_d;
			presc_q <= presc_d;
			run_q   <= run_d;
			hold_q  <= hold_d;
			flags_q <= flags_d;
			cap_q   <= cap_d;
			pins_q  <= pins_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_word_q.timer_count       <= count_d;
			out_word_q.flag_bits         <= flags_d;
			out_word_q.interrupt_request <= |flags_d;
			out_word_q.captured_value_0  <= cap_d[0];
			out_word_q.captured_value_1  <= cap_d[1];
		end
	end

`ifndef SYNTHESIS
	a_hold_keeps_prescaler_clear: assert property (@(posedge clk) disable iff (!arst_n)
		hold_q |-> presc_q == '0)
		else $error("Prescaler moved while the timer is held in reset.");

	a_flags_set_only_by_tick: assert property (@(posedge clk) disable iff (!arst_n)
		adv && in_word_s1.op != OP_TICK |=> (flags_q & ~$past(flags_q)) == '0)
		else $error("A flag was raised by a word that is not a tick.");

	a_irq_matches_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_word_q.interrupt_request == (|out_word_q.flag_bits))
		else $error("Interrupt request disagrees with the pending flags.");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("Input stalled while the pipeline could move.");
`endif

endmodule

`default_nettype wire
